### sv/lsc_pkg.sv
// shared types and constants for the line segment clipper
// no dependencies
`timescale 1ns / 1ps
package lsc_pkg;
  localparam int CoordBits = 16;
  localparam int MaxPasses = 4;
  localparam int ProdBits = 2 * CoordBits + 2;
  localparam int DenBits = CoordBits + 1;

  localparam logic [3:0] CODE_LEFT = 4'd1;
  localparam logic [3:0] CODE_RIGHT = 4'd2;
  localparam logic [3:0] CODE_BOT = 4'd4;
  localparam logic [3:0] CODE_TOP = 4'd8;

  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_Y_MIN = 2'd1;
  localparam logic [1:0] REG_X_MAX = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } seg_in_t;

  typedef struct packed {
    logic visible;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } seg_out_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } window_t;

  // classified item handed from front to back
  typedef struct packed {
    seg_in_t seg;
    logic [3:0] code0;
    logic [3:0] code1;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_MUL, ST_DIV, ST_FIX, ST_DONE
  } back_state_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, window_t w);
    logic [3:0] c;
    c = 4'd0;
    if (w.x_min > x) c = c | CODE_LEFT;
    if (w.x_max < x) c = c | CODE_RIGHT;
    if (w.y_min > y) c = c | CODE_BOT;
    if (w.y_max < y) c = c | CODE_TOP;
    return c;
  endfunction
endpackage

### sv/line_segment_clipper_unit.sv
// top level of the cohen-sutherland line clipper
// depends on lsc_pkg, lsc_front, lsc_back
`timescale 1ns / 1ps
// Clips one segment per transfer against the window held in four registers
// (x min, y min, x max, y max; written through cfg_we/cfg_index/cfg_data, which
// the user must do only while idle; the block does not enforce it). The front end
// takes a segment, computes both 4-bit outcodes and queues it in a two-entry
// fifo; the back end runs up to four clip passes. Each pass is a classify step,
// a multiply step that also starts the shared restoring divider, the divider
// run and an update step. A segment that is trivially accepted or rejected
// takes no pass. Intersections round to nearest, ties away from zero, and
// saturate to the coordinate range. A finished result sits in an output
// register so the next segment can start while it waits.
module line_segment_clipper_unit import lsc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  coord_t     cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  seg_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output seg_out_t   out_data
);
  window_t win;
  logic job_valid, job_ready;
  job_t job;

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      win.x_min <= CoordBits'(0);
      win.y_min <= CoordBits'(0);
      win.x_max <= CoordBits'(1023);
      win.y_max <= CoordBits'(1023);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_X_MIN: win.x_min <= cfg_data;
        REG_Y_MIN: win.y_min <= cfg_data;
        REG_X_MAX: win.x_max <= cfg_data;
        REG_Y_MAX: win.y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  lsc_front u_front (
    .clk(clk), .rst(rst), .win(win),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  lsc_back u_back (
    .clk(clk), .rst(rst), .win(win),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

### sv/lsc_front.sv
// front part: takes segments, computes both outcodes, two-entry queue
// depends on lsc_pkg
`timescale 1ns / 1ps
module lsc_front import lsc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  window_t win,
  input  logic    in_valid,
  output logic    in_ready,
  input  seg_in_t in_data,
  output logic    job_valid,
  input  logic    job_ready,
  output job_t    job
);
  job_t q [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;
  job_t newjob;

  always_comb begin
    newjob.seg = in_data;
    newjob.code0 = outcode(in_data.start_x, in_data.start_y, win);
    newjob.code1 = outcode(in_data.end_x, in_data.end_y, win);
  end

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign job_valid = (count != 2'd0);
  assign pop = job_valid && job_ready;
  assign job = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= newjob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("bad count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 2'd1) else $error("count step");
`endif
endmodule

### sv/lsc_divider.sv
// restoring serial divider, one quotient bit per cycle, unsigned
// depends on lsc_pkg
`timescale 1ns / 1ps
module lsc_divider import lsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [ProdBits-1:0]  dividend,
  input  logic [DenBits-1:0]   divisor,
  output logic                 done,
  output logic [ProdBits-1:0]  quotient,
  output logic [DenBits-1:0]   remainder
);
  localparam int CntBits = $clog2(ProdBits + 1);
  logic [CntBits-1:0] cnt;
  logic busy;
  logic [ProdBits-1:0] num;
  logic [DenBits-1:0] den;
  logic [DenBits:0] trial;

  assign trial = {remainder, num[ProdBits-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      remainder <= '0;
      quotient <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (!trial[DenBits]) begin
        remainder <= trial[DenBits-1:0];
        quotient <= {quotient[ProdBits-2:0], 1'b1};
      end else begin
        remainder <= {remainder[DenBits-2:0], num[ProdBits-1]};
        quotient <= {quotient[ProdBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntBits'(ProdBits);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### sv/lsc_back.sv
// back part: clip passes with shared multiplier and serial divider, result register
// depends on lsc_pkg, lsc_divider
`timescale 1ns / 1ps
module lsc_back import lsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  window_t  win,
  input  logic     job_valid,
  output logic     job_ready,
  input  job_t     job,
  output logic     out_valid,
  input  logic     out_ready,
  output seg_out_t out_data
);
  localparam logic signed [ProdBits+1:0] SumMax = (ProdBits+2)'(2**(CoordBits-1) - 1);
  localparam logic signed [ProdBits+1:0] SumMin = (ProdBits+2)'(-(2**(CoordBits-1)));

  back_state_t state, state_next;
  coord_t p0x, p0y, p1x, p1y;
  logic [3:0] c0, c1;
  logic [2:0] pass;
  logic rejected;

  // pass operands
  logic k;
  logic [3:0] c;
  logic horiz;
  coord_t edge_v, base;
  logic signed [CoordBits:0] dx, dy, pnum, qnum, dnum;
  logic signed [ProdBits-1:0] prod;
  logic [ProdBits-1:0] prod_mag;
  logic neg;
  logic [DenBits-1:0] den_mag;

  // registered pass context
  logic k_r, horiz_r, neg_r;
  coord_t edge_r, base_r;
  logic signed [CoordBits:0] pnum_r, qnum_r;
  logic [DenBits-1:0] den_r;

  logic div_start, div_done;
  logic [ProdBits-1:0] quo;
  logic [DenBits-1:0] rem;

  logic [ProdBits-1:0] quo_rnd;
  logic signed [ProdBits+1:0] sum;
  coord_t moved;
  coord_t nx, ny;

  logic busy_pass_done;

  always_comb begin
    k = (c0 == 4'd0);
    c = k ? c1 : c0;
    horiz = (c & (CODE_LEFT | CODE_RIGHT)) != 4'd0;
    dx = {p0x[CoordBits-1], p0x} - {p1x[CoordBits-1], p1x};
    dy = {p0y[CoordBits-1], p0y} - {p1y[CoordBits-1], p1y};
    if (horiz) begin
      edge_v = (c & CODE_LEFT) != 4'd0 ? win.x_min : win.x_max;
      base = k ? p1y : p0y;
      pnum = dy;
      qnum = {edge_v[CoordBits-1], edge_v} - (k ? {p1x[CoordBits-1], p1x}
                                                : {p0x[CoordBits-1], p0x});
      dnum = dx;
    end else begin
      edge_v = (c & CODE_BOT) != 4'd0 ? win.y_min : win.y_max;
      base = k ? p1x : p0x;
      pnum = dx;
      qnum = {edge_v[CoordBits-1], edge_v} - (k ? {p1y[CoordBits-1], p1y}
                                                : {p0y[CoordBits-1], p0y});
      dnum = dy;
    end
    neg = ((pnum < 0) != (qnum < 0)) != (dnum < 0);
    den_mag = dnum < 0 ? DenBits'(-dnum) : DenBits'(dnum);
  end

  // multiply in its own cycle from registered operands, straight into the divider
  assign prod = ProdBits'(pnum_r) * ProdBits'(qnum_r);
  assign prod_mag = prod < 0 ? ProdBits'(-prod) : ProdBits'(prod);

  lsc_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(prod_mag), .divisor(den_r),
    .done(div_done), .quotient(quo), .remainder(rem)
  );

  always_comb begin
    quo_rnd = quo + ProdBits'({rem, 1'b0} >= {1'b0, den_r});
    if (den_r == '0)
      sum = (ProdBits+2)'(base_r);
    else if (neg_r)
      sum = (ProdBits+2)'(base_r) - (ProdBits+2)'(quo_rnd);
    else
      sum = (ProdBits+2)'(base_r) + (ProdBits+2)'(quo_rnd);
    if (sum > SumMax)
      moved = {1'b0, {(CoordBits-1){1'b1}}};
    else if (sum < SumMin)
      moved = {1'b1, {(CoordBits-1){1'b0}}};
    else
      moved = sum[CoordBits-1:0];
    nx = horiz_r ? edge_r : moved;
    ny = horiz_r ? moved : edge_r;
  end

  assign busy_pass_done = (c0 | c1) == 4'd0 || (c0 & c1) != 4'd0
                          || pass == 3'(MaxPasses);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (job_valid) state_next = ST_CHECK;
      ST_CHECK: state_next = busy_pass_done ? ST_DONE : ST_MUL;
      ST_MUL: state_next = ST_DIV;
      ST_DIV: if (div_done) state_next = ST_FIX;
      ST_FIX: state_next = ST_CHECK;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == ST_IDLE);
    div_start = (state == ST_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (job_valid) begin
        p0x <= job.seg.start_x; p0y <= job.seg.start_y;
        p1x <= job.seg.end_x; p1y <= job.seg.end_y;
        c0 <= job.code0; c1 <= job.code1;
        pass <= '0;
      end
      ST_CHECK: begin
        rejected <= (c0 & c1) != 4'd0;
        k_r <= k; horiz_r <= horiz; neg_r <= neg;
        edge_r <= edge_v; base_r <= base;
        pnum_r <= pnum; qnum_r <= qnum; den_r <= den_mag;
      end
      ST_FIX: begin
        pass <= pass + 3'd1;
        if (k_r) begin
          p1x <= nx; p1y <= ny; c1 <= outcode(nx, ny, win);
        end else begin
          p0x <= nx; p0y <= ny; c0 <= outcode(nx, ny, win);
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_data.visible <= !rejected && (c0 | c1) == 4'd0;
      out_data.clipped_start_x <= p0x;
      out_data.clipped_start_y <= p0y;
      out_data.clipped_end_x <= p1x;
      out_data.clipped_end_y <= p1y;
    end
  end

`ifndef SYNTHESIS
  a_pass_limit: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> pass < 3'(MaxPasses)) else $error("too many passes");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV) else $error("stray divider done");
  a_visible_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) && out_data.visible |->
    $past((c0 | c1) == 4'd0)) else $error("visible with outside endpoint");
`endif
endmodule
